@@ rtl/core/bdfp_pkg.sv @@
`default_nettype none

package bdfp_pkg;

	// Characters the frame grammar cares about
	localparam logic [7:0] CH_OPEN  = 8'h5B; // '['
	localparam logic [7:0] CH_CLOSE = 8'h5D; // ']'
	localparam logic [7:0] CH_COMMA = 8'h2C; // ','
	localparam logic [7:0] CH_HASH  = 8'h23; // '#'
	localparam logic [7:0] CH_0     = 8'h30; // '0'
	localparam logic [7:0] CH_9     = 8'h39; // '9'

	localparam logic [2:0] POS_MAX = 3'd7;

	// Field slots
	localparam logic [1:0] FLD_X    = 2'd0;
	localparam logic [1:0] FLD_Y    = 2'd1;
	localparam logic [1:0] FLD_DIST = 2'd2;

	// Frame modes
	localparam logic MODE_XYD  = 1'b0;
	localparam logic MODE_STOP = 1'b1;

	typedef enum logic [2:0] {
		PH_START,
		PH_FIELDS,
		PH_STOP,
		PH_ACCEPT,
		PH_REJECT,
		PH_STOPPED
	} phase_t;

	// Per-frame control state
	typedef struct packed {
		phase_t     phase;
		logic [2:0] pos;
		logic [1:0] field;
	} frame_ctl_t;

	localparam frame_ctl_t CTL_IDLE = '{phase: PH_START, pos: 3'd0, field: FLD_X};

	// Letters of the stop command, indexed by byte position minus one
	function automatic logic [7:0] stop_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h73; // 's'
			2'd1: c = 8'h74; // 't'
			2'd2: c = 8'h6F; // 'o'
			2'd3: c = 8'h70; // 'p'
			default: c = 8'h73;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/bdfp_step.sv @@
`default_nettype none

// Next-state logic for one received byte
module bdfp_step #(
	parameter int VALUE_WIDTH = 16
) (
	input  wire logic                    frame_mode,
	input  wire logic [7:0]              rx_byte,
	input  wire bdfp_pkg::frame_ctl_t    ctl,
	input  wire logic [VALUE_WIDTH-1:0]  acc_first,
	input  wire logic [VALUE_WIDTH-1:0]  acc_second,
	input  wire logic [VALUE_WIDTH-1:0]  acc_third,
	input  wire logic [VALUE_WIDTH-1:0]  held_x,
	input  wire logic [VALUE_WIDTH-1:0]  held_y,
	input  wire logic [VALUE_WIDTH-1:0]  held_distance,
	output bdfp_pkg::frame_ctl_t         ctl_next,
	output logic      [VALUE_WIDTH-1:0]  acc_first_next,
	output logic      [VALUE_WIDTH-1:0]  acc_second_next,
	output logic      [VALUE_WIDTH-1:0]  acc_third_next,
	output logic      [VALUE_WIDTH-1:0]  held_x_next,
	output logic      [VALUE_WIDTH-1:0]  held_y_next,
	output logic      [VALUE_WIDTH-1:0]  held_distance_next
);
	import bdfp_pkg::*;

	logic [1:0]             last_field;
	logic                   is_digit;
	logic [VALUE_WIDTH-1:0] digit;
	logic [VALUE_WIDTH-1:0] acc_sel;
	logic [VALUE_WIDTH-1:0] acc_new;
	logic                   stop_hit;

	// Select the accumulator of the current field, fold in the digit and match the stop letter
	always_comb begin
		last_field = (frame_mode == MODE_STOP) ? FLD_Y : FLD_DIST;
		is_digit   = rx_byte inside {[CH_0:CH_9]};
		digit      = VALUE_WIDTH'(rx_byte[3:0]);
		case (ctl.field)
			FLD_X:   acc_sel = acc_first;
			FLD_Y:   acc_sel = acc_second;
			default: acc_sel = acc_third;
		endcase
		acc_new  = (acc_sel << 3) + (acc_sel << 1) + digit;
		stop_hit = (ctl.pos >= 3'd1) && (ctl.pos <= 3'd4)
			&& (rx_byte == stop_char(2'(ctl.pos - 3'd1)));
	end

	// Advance the frame state by one byte
	always_comb begin
		ctl_next           = ctl;
		acc_first_next     = acc_first;
		acc_second_next    = acc_second;
		acc_third_next     = acc_third;
		held_x_next        = held_x;
		held_y_next        = held_y;
		held_distance_next = held_distance;

		if (ctl.pos < POS_MAX) begin
			ctl_next.pos = ctl.pos + 3'd1;
		end

		case (ctl.phase)
			PH_START: begin
				if (rx_byte == CH_OPEN) begin
					ctl_next.phase = PH_FIELDS;
				end else if (rx_byte == CH_HASH && frame_mode == MODE_STOP) begin
					ctl_next.phase = PH_STOP;
				end else begin
					ctl_next.phase = PH_REJECT;
				end
			end
			PH_FIELDS: begin
				if (is_digit) begin
					case (ctl.field)
						FLD_X:   acc_first_next  = acc_new;
						FLD_Y:   acc_second_next = acc_new;
						default: acc_third_next  = acc_new;
					endcase
				end else if (rx_byte == CH_COMMA && ctl.field < last_field) begin
					ctl_next.field = ctl.field + 2'd1;
				end else if (rx_byte == CH_CLOSE) begin
					held_x_next = acc_first;
					held_y_next = acc_second;
					if (frame_mode == MODE_XYD) begin
						held_distance_next = acc_third;
					end
					ctl_next.phase = PH_ACCEPT;
				end else begin
					ctl_next.phase = PH_REJECT;
				end
			end
			PH_STOP: begin
				if (stop_hit) begin
					ctl_next.phase = (ctl.pos == 3'd4) ? PH_STOPPED : PH_STOP;
				end else begin
					ctl_next.phase = PH_REJECT;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/bracketed_decimal_frame_parser_core.sv @@
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  rx_byte, end_of_frame
// result    out        out_valid/out_stall  coord_accepted, pos_x, pos_y, distance,
//                                           stop_request
// config    in         cfg_wr_en            cfg_wr_data (frame_mode)
//
// One byte per cycle unless a stalled result holds the input: a byte is captured in the input
// stage and parsed from there. A frame's result is registered when its last byte is parsed,
// so it is offered from the result register, after the input stage.
// The parse state loop (phase, field, accumulators) closes through the step logic and the state registers.
// Reset clears the mode, the frame state and the held values; no clearing pass.
// A stalled result only holds back a frame's last byte, and new bytes behind it; other bytes keep flowing.
module bracketed_decimal_frame_parser_core #(
	parameter int VALUE_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    rx_byte,
	input  wire logic                          end_of_frame,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               coord_accepted,
	output logic signed [VALUE_WIDTH-1:0]      pos_x,
	output logic signed [VALUE_WIDTH-1:0]      pos_y,
	output logic signed [VALUE_WIDTH-1:0]      distance,
	output logic                               stop_request
);
	import bdfp_pkg::*;

	logic                   mode_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   eof_s1;
	frame_ctl_t             ctl_q;
	frame_ctl_t             ctl_next;
	logic [VALUE_WIDTH-1:0] acc_first_q, acc_second_q, acc_third_q;
	logic [VALUE_WIDTH-1:0] acc_first_next, acc_second_next, acc_third_next;
	logic [VALUE_WIDTH-1:0] held_x_q, held_y_q, held_distance_q;
	logic [VALUE_WIDTH-1:0] held_x_next, held_y_next, held_distance_next;
	logic                   out_free;
	logic                   go_s1;
	logic                   in_xfer;

	// Flow control
	assign out_free = !out_valid || !out_stall;
	assign go_s1    = valid_s1 && (!eof_s1 || out_free);
	assign in_stall = valid_s1 && !go_s1;
	assign in_xfer  = in_valid && !in_stall;

	// Hold the frame mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_XYD;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= rx_byte;
			eof_s1  <= end_of_frame;
		end
	end

	bdfp_step #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_step (
		.frame_mode         (mode_q),
		.rx_byte            (byte_s1),
		.ctl                (ctl_q),
		.acc_first          (acc_first_q),
		.acc_second         (acc_second_q),
		.acc_third          (acc_third_q),
		.held_x             (held_x_q),
		.held_y             (held_y_q),
		.held_distance      (held_distance_q),
		.ctl_next           (ctl_next),
		.acc_first_next     (acc_first_next),
		.acc_second_next    (acc_second_next),
		.acc_third_next     (acc_third_next),
		.held_x_next        (held_x_next),
		.held_y_next        (held_y_next),
		.held_distance_next (held_distance_next)
	);

	// Advance the frame state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q           <= CTL_IDLE;
			acc_first_q     <= '0;
			acc_second_q    <= '0;
			acc_third_q     <= '0;
			held_x_q        <= '0;
			held_y_q        <= '0;
			held_distance_q <= '0;
		end else if (go_s1) begin
			held_x_q        <= held_x_next;
			held_y_q        <= held_y_next;
			held_distance_q <= held_distance_next;
			if (eof_s1) begin
				ctl_q        <= CTL_IDLE;
				acc_first_q  <= '0;
				acc_second_q <= '0;
				acc_third_q  <= '0;
			end else begin
				ctl_q        <= ctl_next;
				acc_first_q  <= acc_first_next;
				acc_second_q <= acc_second_next;
				acc_third_q  <= acc_third_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go_s1 && eof_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && eof_s1) begin
			coord_accepted <= (ctl_next.phase == PH_ACCEPT);
			stop_request   <= (ctl_next.phase == PH_STOPPED);
			pos_x          <= held_x_next;
			pos_y          <= held_y_next;
			distance       <= held_distance_next;
		end
	end

endmodule

`default_nettype wire
